FILE: hw/rtl/binary_arithmetic_encoder_defines.svh
// Assertion macros shared by the binary arithmetic encoder RTL.
`ifndef BINARY_ARITHMETIC_ENCODER_DEFINES_SVH
`define BINARY_ARITHMETIC_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define BAE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BAE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BAE_ASSERT(label, prop, msg)
`define BAE_ASSERT_IMPL(label, ante, cons, msg)
`define BAE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/bae_pkg.sv
// Types and constants of the binary arithmetic encoder.
package bae_pkg;

    localparam int BoundBits = 32;
    localparam int WordBits  = 16;
    localparam int ProbBits  = 8;
    localparam int ProdBits  = BoundBits + ProbBits;
    localparam int MaxRenorm = 2;
    localparam int CntBits   = 2;

    localparam logic [BoundBits-1:0] LowReset  = '0;
    localparam logic [BoundBits-1:0] HighReset = '1;
    localparam logic [WordBits-1:0]  WordFill  = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RENORM,
        ST_SPLIT,
        ST_FLUSH_HI,
        ST_FLUSH_LO
    } state_t;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_FLUSH  = 1'b1
    } mode_t;

endpackage

FILE: hw/rtl/binary_arithmetic_encoder.sv
// Binary arithmetic encoder: 32-bit interval coder emitting 16-bit code words.
//
// Input channel: in_valid / in_stall with fields mode, bit_value and zero_prob.
// A beat with mode 0 encodes one bit, a beat with mode 1 flushes the coder.
// Output channel: out_valid / out_stall with fields code_word and last; last
// marks the final word caused by one input beat. Encode beats give zero to two
// words, flush beats exactly two.
// An encode beat passes ST_RENORM, which checks for renormalization, emits up
// to two words and loads the 32x8 product register, then ST_SPLIT, which adds
// the product to the low bound to set the new low or high bound; the next beat
// is taken in the split state. A flush emits the high bound in ST_FLUSH_HI and
// ST_FLUSH_LO, then returns to ST_IDLE. The single output register holds a
// word until it is taken; while out_stall is high the sequencer waits at the
// next emission and in_stall stays high.
// Reset sets the bounds to 0x00000000 and 0xffffffff and empties the output
// register; no clearing pass is needed.
`include "binary_arithmetic_encoder_defines.svh"

module binary_arithmetic_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic                         bit_value,
    input  logic [bae_pkg::ProbBits-1:0] zero_prob,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bae_pkg::WordBits-1:0] code_word,
    output logic                         last
);

    bae_pkg::state_t state_reg, state_next;

    logic [bae_pkg::BoundBits-1:0] low_reg, low_next;
    logic [bae_pkg::BoundBits-1:0] high_reg, high_next;
    logic [bae_pkg::ProdBits-1:0]  prod_reg, prod_next;
    logic [bae_pkg::CntBits-1:0]   cnt_reg, cnt_next;
    logic                          bit_reg, bit_next;
    logic [bae_pkg::ProbBits-1:0]  prob_reg, prob_next;
    logic                          out_valid_reg, out_valid_next;
    logic [bae_pkg::WordBits-1:0]  word_reg, word_next;
    logic                          last_reg, last_next;

    logic                          accept;
    logic                          out_free;
    logic                          renorm_due;
    logic [bae_pkg::BoundBits-1:0] diff;
    logic [bae_pkg::BoundBits-1:0] split;

    assign in_stall   = !(state_reg == bae_pkg::ST_IDLE || state_reg == bae_pkg::ST_SPLIT);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign renorm_due = (low_reg[bae_pkg::BoundBits-1 -: bae_pkg::WordBits] ==
                         high_reg[bae_pkg::BoundBits-1 -: bae_pkg::WordBits]) &&
                        (cnt_reg != bae_pkg::CntBits'(bae_pkg::MaxRenorm));
    assign diff       = high_reg - low_reg;
    assign split      = low_reg + prod_reg[bae_pkg::ProdBits-1 -: bae_pkg::BoundBits];

    assign out_valid = out_valid_reg;
    assign code_word = word_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bae_pkg::ST_IDLE, bae_pkg::ST_SPLIT:
            begin
                if (accept)
                begin
                    state_next = (bae_pkg::mode_t'(mode) == bae_pkg::MODE_FLUSH) ?
                                 bae_pkg::ST_FLUSH_HI : bae_pkg::ST_RENORM;
                end
                else
                begin
                    state_next = bae_pkg::ST_IDLE;
                end
            end
            bae_pkg::ST_RENORM:
            begin
                if (!renorm_due)
                begin
                    state_next = bae_pkg::ST_SPLIT;
                end
            end
            bae_pkg::ST_FLUSH_HI:
            begin
                if (out_free)
                begin
                    state_next = bae_pkg::ST_FLUSH_LO;
                end
            end
            bae_pkg::ST_FLUSH_LO:
            begin
                if (out_free)
                begin
                    state_next = bae_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bae_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        low_next       = low_reg;
        high_next      = high_reg;
        prod_next      = diff * bae_pkg::ProdBits'(prob_reg);
        cnt_next       = cnt_reg;
        bit_next       = bit_reg;
        prob_next      = prob_reg;
        out_valid_next = out_valid_reg && out_stall;
        word_next      = word_reg;
        last_next      = last_reg;

        if (accept)
        begin
            bit_next  = bit_value;
            prob_next = zero_prob;
            cnt_next  = '0;
        end

        unique case (state_reg)
            bae_pkg::ST_IDLE:
            begin
            end
            bae_pkg::ST_SPLIT:
            begin
                if (bit_reg)
                begin
                    low_next = split + bae_pkg::BoundBits'(1);
                end
                else
                begin
                    high_next = split;
                end
            end
            bae_pkg::ST_RENORM:
            begin
                if (renorm_due && out_free)
                begin
                    out_valid_next = 1'b1;
                    word_next      = high_reg[bae_pkg::BoundBits-1 -: bae_pkg::WordBits];
                    last_next      = (cnt_reg == bae_pkg::CntBits'(bae_pkg::MaxRenorm - 1)) ||
                                     (low_reg[bae_pkg::WordBits-1:0] !=
                                      high_reg[bae_pkg::WordBits-1:0]);
                    low_next       = {low_reg[bae_pkg::WordBits-1:0],
                                      {bae_pkg::WordBits{1'b0}}};
                    high_next      = {high_reg[bae_pkg::WordBits-1:0], bae_pkg::WordFill};
                    cnt_next       = cnt_reg + bae_pkg::CntBits'(1);
                end
            end
            bae_pkg::ST_FLUSH_HI:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    word_next      = high_reg[bae_pkg::BoundBits-1 -: bae_pkg::WordBits];
                    last_next      = 1'b0;
                end
            end
            bae_pkg::ST_FLUSH_LO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    word_next      = high_reg[bae_pkg::WordBits-1:0];
                    last_next      = 1'b1;
                    low_next       = bae_pkg::LowReset;
                    high_next      = bae_pkg::HighReset;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bae_pkg::ST_IDLE;
            low_reg       <= bae_pkg::LowReset;
            high_reg      <= bae_pkg::HighReset;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        bit_reg  <= bit_next;
        prob_reg <= prob_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    `BAE_ASSERT(a_cnt_bound, cnt_reg <= bae_pkg::CntBits'(bae_pkg::MaxRenorm), "renorm count overflow")
    `BAE_ASSERT_NEXT(a_flush_reset, state_reg == bae_pkg::ST_FLUSH_LO && out_free, low_reg == bae_pkg::LowReset && high_reg == bae_pkg::HighReset && out_valid_reg && last_reg, "flush did not reset bounds")
    `BAE_ASSERT_NEXT(a_more_words, state_reg == bae_pkg::ST_RENORM && renorm_due && out_free && !last_next, state_reg == bae_pkg::ST_RENORM, "word without last not followed by renorm")
    `BAE_ASSERT_IMPL(a_word_source, $rose(out_valid_reg), $past(state_reg) == bae_pkg::ST_RENORM || $past(state_reg) == bae_pkg::ST_FLUSH_HI || $past(state_reg) == bae_pkg::ST_FLUSH_LO, "word emitted from wrong state")

endmodule

FILE: tb/binary_arithmetic_encoder_test.sv
// Self-checking testbench of the binary arithmetic encoder with a scoreboard and random stimulus.
`timescale 1ns / 100ps

typedef struct packed {
    logic [bae_pkg::WordBits-1:0] word;
    logic                         last;
} coded_word_t;

class encoder_scoreboard;
    logic [bae_pkg::BoundBits-1:0] bound_low;
    logic [bae_pkg::BoundBits-1:0] bound_high;
    coded_word_t                   word_q[$];
    int                            errors;

    function new();
        bound_low  = bae_pkg::LowReset;
        bound_high = bae_pkg::HighReset;
        errors     = 0;
    endfunction

    function void push_word(logic [bae_pkg::WordBits-1:0] w, logic l);
        coded_word_t item;
        item.word = w;
        item.last = l;
        word_q.insert(word_q.size(), item);
    endfunction

    // Works out the words that one accepted input beat produces.
    function void note_beat(bae_pkg::mode_t m, logic b, logic [bae_pkg::ProbBits-1:0] p);
        logic [bae_pkg::ProdBits-1:0]  prod;
        logic [bae_pkg::BoundBits-1:0] diff;
        logic [bae_pkg::BoundBits-1:0] split;
        int                            shifts;
        shifts = 0;
        if (m == bae_pkg::MODE_FLUSH)
        begin
            push_word(bound_high[31:16], 1'b0);
            push_word(bound_high[15:0], 1'b1);
            bound_low  = bae_pkg::LowReset;
            bound_high = bae_pkg::HighReset;
            return;
        end
        while (shifts < bae_pkg::MaxRenorm && bound_low[31:16] == bound_high[31:16])
        begin
            push_word(bound_high[31:16], 1'b0);
            bound_low  = {bound_low[15:0], 16'h0000};
            bound_high = {bound_high[15:0], bae_pkg::WordFill};
            shifts++;
        end
        if (shifts > 0)
            word_q[word_q.size()-1].last = 1'b1;
        diff  = bound_high - bound_low;
        prod  = {8'h00, diff} * {32'h0, p};
        split = bound_low + prod[bae_pkg::ProdBits-1:bae_pkg::ProbBits];
        if (b)
            bound_low = split + 1;
        else
            bound_high = split;
    endfunction

    function void check_word(logic [bae_pkg::WordBits-1:0] w, logic l);
        coded_word_t want;
        if (word_q.size() == 0)
        begin
            $error("unexpected code word %h with last %b", w, l);
            errors++;
            return;
        end
        want = word_q.pop_front();
        if (w !== want.word)
        begin
            $error("code_word mismatch: expected %h, actual %h", want.word, w);
            errors++;
        end
        if (l !== want.last)
        begin
            $error("last mismatch: expected %b, actual %b", want.last, l);
            errors++;
        end
    endfunction

    function int pending();
        return word_q.size();
    endfunction
endclass

module binary_arithmetic_encoder_test;
    import bae_pkg::*;

    localparam int RandomItems = 480;
    localparam int HoldCycles  = 300;
    localparam int StuckLimit  = 3000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                mode;
    logic                bit_value;
    logic [ProbBits-1:0] zero_prob;
    logic                out_valid;
    logic                out_stall;
    logic [WordBits-1:0] code_word;
    logic                last;

    encoder_scoreboard coder_sb;
    logic              quiet;
    logic              hold_start;

    binary_arithmetic_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .bit_value (bit_value),
        .zero_prob (zero_prob),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_word (code_word),
        .last      (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_beat(input mode_t m, input logic b, input logic [ProbBits-1:0] p);
        in_valid  <= 1'b1;
        mode      <= m;
        bit_value <= b;
        zero_prob <= p;
        do
            @(posedge clk);
        while (in_stall);
        coder_sb.note_beat(m, b, p);
        if (!quiet && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic send_random_beat();
        mode_t               m;
        logic [ProbBits-1:0] p;
        m = ($urandom_range(15) == 0) ? MODE_FLUSH : MODE_ENCODE;
        case ($urandom_range(7))
            0: p = 8'd0;
            1: p = 8'd255;
            2: p = 8'd1;
            default: p = 8'($urandom_range(255));
        endcase
        send_beat(m, 1'($urandom_range(1)), p);
    endtask

    initial
    begin
        coder_sb   = new();
        quiet      = 1'b0;
        hold_start = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_ENCODE;
        bit_value  = 1'b0;
        zero_prob  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(MODE_FLUSH, 1'b1, 8'hff);
        send_beat(MODE_ENCODE, 1'b0, 8'd0);
        send_beat(MODE_ENCODE, 1'b1, 8'd255);
        send_beat(MODE_FLUSH, 1'b0, 8'h00);
        send_beat(MODE_ENCODE, 1'b0, 8'd1);
        send_beat(MODE_ENCODE, 1'b0, 8'd1);
        send_beat(MODE_ENCODE, 1'b1, 8'd255);
        send_beat(MODE_ENCODE, 1'b1, 8'd254);
        send_beat(MODE_ENCODE, 1'b1, 8'd254);
        send_beat(MODE_ENCODE, 1'b1, 8'd0);
        send_beat(MODE_ENCODE, 1'b0, 8'd128);
        send_beat(MODE_ENCODE, 1'b0, 8'd0);
        send_beat(MODE_ENCODE, 1'b0, 8'd0);
        send_beat(MODE_ENCODE, 1'b1, 8'd170);
        send_beat(MODE_ENCODE, 1'b0, 8'd85);
        send_beat(MODE_FLUSH, 1'b1, 8'h55);
        send_beat(MODE_ENCODE, 1'b1, 8'd255);
        send_beat(MODE_FLUSH, 1'b0, 8'haa);

        for (int n = 0; n < RandomItems; n++)
        begin
            quiet = (n >= 200 && n < 280);
            if (n == 100)
                hold_start = 1'b1;
            send_random_beat();
        end
        quiet    = 1'b0;
        in_valid <= 1'b0;

        while (coder_sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (coder_sb.errors == 0 && coder_sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // The receiver; a long hold-off lets the block fill up and stall its input.
    initial
    begin : receiver
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                coder_sb.check_word(code_word, last);
            if (hold_start && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 34);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
            if (stuck >= StuckLimit)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end
endmodule
